/* rtl/utf8ed_pkg.sv */
// Shared types, character codes and entity tables of the UTF-8 and entity text decoder.
package utf8ed_pkg;

   localparam int unsigned ByteW         = 8;
   localparam int unsigned CpW           = 26;
   localparam int unsigned UsedW         = 3;
   localparam int unsigned CntW          = 3;
   localparam int unsigned NumValW       = 10;
   localparam int unsigned NumEnt        = 6;
   localparam int unsigned EntMaxLen     = 6;
   localparam int unsigned LaDepth       = 5;
   localparam int unsigned LaIdxW        = $clog2(LaDepth);
   localparam int unsigned RspDataW      = ((CpW + UsedW + 7) / 8) * 8;
   localparam int unsigned QueueDepthDef = 4;

   // character codes
   localparam logic [ByteW-1:0] CharAmp    = 8'h26;
   localparam logic [ByteW-1:0] CharBslash = 8'h5C;
   localparam logic [ByteW-1:0] CharHash   = 8'h23;
   localparam logic [ByteW-1:0] CharU      = 8'h75;
   localparam logic [ByteW-1:0] CharZero   = 8'h30;
   localparam logic [ByteW-1:0] CharNine   = 8'h39;
   localparam logic [ByteW-1:0] CharSpace  = 8'h20;
   localparam logic [ByteW-1:0] AsciiTop   = 8'h7F;

   // &apos; &amp; &lt; &gt; &nbsp; &quot;
   localparam logic [ByteW-1:0] EntChar [NumEnt][EntMaxLen] = '{
      '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
      '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
      '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
      '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
      '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B},
      '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}
   };
   localparam logic [CntW-1:0]  EntLen [NumEnt] = '{3'd6, 3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
   localparam logic [ByteW-1:0] EntVal [NumEnt] = '{8'd39, 8'd38, 8'd60, 8'd62, 8'd32, 8'd34};

   typedef enum logic [1:0] {
      CLS_PLAIN,
      CLS_LEAD,
      CLS_AMP,
      CLS_BSLASH
   } cls_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_UTF,
      MODE_ENTITY,
      MODE_NUMERIC,
      MODE_BSLASH,
      MODE_BSU
   } mode_type;

   typedef enum logic [1:0] {
      PH_FEED,
      PH_REPLAY,
      PH_FLUSH,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] text_byte;
      logic             end_of_text;
      cls_type          cls;
      logic [2:0]       extra;
      logic [4:0]       lead_val;
   } item_type;

endpackage

/* rtl/utf8ed_front.sv */
// Front end: accepts input bytes, classifies them and queues them for the decode engine.
module utf8ed_front import utf8ed_pkg::*; #(
   parameter int unsigned QueueDepth = QueueDepthDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ByteW-1:0] req_tdata,
   input  logic             req_tlast,
   output logic             hd_valid,
   output item_type         hd_item,
   input  logic             hd_pop
);

   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QCntW = $clog2(QueueDepth + 1);

   item_type         q_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] fill_ff, fill_in;
   item_type         cls_item;
   logic             push;

   // classify the incoming byte
   always_comb begin
      cls_item.text_byte   = req_tdata;
      cls_item.end_of_text = req_tlast;
      cls_item.cls         = CLS_PLAIN;
      cls_item.extra       = 3'd0;
      cls_item.lead_val    = 5'd0;
      if (req_tdata > AsciiTop) begin
         cls_item.cls = CLS_LEAD;
         if (!req_tdata[5]) begin
            cls_item.extra    = 3'd1;
            cls_item.lead_val = req_tdata[4:0];
         end else if (!req_tdata[4]) begin
            cls_item.extra    = 3'd2;
            cls_item.lead_val = {1'b0, req_tdata[3:0]};
         end else if (!req_tdata[3]) begin
            cls_item.extra    = 3'd3;
            cls_item.lead_val = {2'b0, req_tdata[2:0]};
         end else begin
            cls_item.extra    = 3'd4;
            cls_item.lead_val = {3'b0, req_tdata[1:0]};
         end
      end else if (req_tdata == CharAmp) begin
         cls_item.cls = CLS_AMP;
      end else if (req_tdata == CharBslash) begin
         cls_item.cls = CLS_BSLASH;
      end
   end

   assign req_tready = (fill_ff != QCntW'(QueueDepth));
   assign push       = req_tvalid && req_tready;
   assign hd_valid   = (fill_ff != '0);
   assign hd_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (hd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !hd_pop) begin
         fill_in = fill_ff + QCntW'(1);
      end else if (!push && hd_pop) begin
         fill_in = fill_ff - QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

/* rtl/utf8ed_back.sv */
// Decode engine: one decode step per cycle on the queued byte unless output stalls, with result and output registers.
module utf8ed_back import utf8ed_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                hd_valid,
   input  item_type            hd_item,
   output logic                hd_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   phase_type          phase_ff, phase_in;
   mode_type           mode_ff, mode_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [CpW-1:0]     acc_ff, acc_in;
   logic [2:0]         cont_ff, cont_in;
   logic [NumEnt-1:0]  match_ff, match_in;
   logic [NumValW-1:0] nval_ff, nval_in;
   logic [1:0]         nd_ff, nd_in;
   logic               nrun_ff, nrun_in;
   logic [ByteW-1:0]   la_ff [LaDepth];
   logic               la_we;
   logic [LaIdxW-1:0]  la_wa;
   logic [LaIdxW-1:0]  rp_ff, rp_in;
   logic [LaIdxW-1:0]  rp_last_ff, rp_last_in;
   logic               refeed_ff, refeed_in;
   logic               pend_v_ff, pend_v_in;
   logic [CpW-1:0]     pend_cp_ff, pend_cp_in;
   logic [UsedW-1:0]   pend_used_ff, pend_used_in;
   logic               out_v_ff, out_v_in;
   logic [CpW-1:0]     out_cp_ff, out_cp_in;
   logic [UsedW-1:0]   out_used_ff, out_used_in;
   logic               out_last_ff, out_last_in;

   logic               go;
   logic               emit;
   logic [CpW-1:0]     em_cp;
   logic [UsedW-1:0]   em_used;
   logic [ByteW-1:0]   b;

   assign go = hd_valid && (!out_v_ff || rsp_tready);
   assign b  = hd_item.text_byte;

   always_comb begin
      logic [CntW-1:0]     c;
      logic [NumEnt-1:0]   still;
      logic                hit;
      logic [ByteW-1:0]    hit_val;
      logic                feed_done;
      logic [NumValW+3:0]  nval_x10;
      logic [NumValW-1:0]  nval_res;

      c         = '0;
      still     = '0;
      hit       = 1'b0;
      hit_val   = '0;
      feed_done = 1'b1;
      nval_x10  = '0;
      nval_res  = (nd_ff != 2'd0) ? nval_ff : NumValW'(CharAmp);

      phase_in     = phase_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      cont_in      = cont_ff;
      match_in     = match_ff;
      nval_in      = nval_ff;
      nd_in        = nd_ff;
      nrun_in      = nrun_ff;
      rp_in        = rp_ff;
      rp_last_in   = rp_last_ff;
      refeed_in    = refeed_ff;
      la_we        = 1'b0;
      la_wa        = LaIdxW'(cnt_ff - CntW'(1));
      emit         = 1'b0;
      em_cp        = '0;
      em_used      = '0;
      hd_pop       = 1'b0;
      pend_v_in    = pend_v_ff;
      pend_cp_in   = pend_cp_ff;
      pend_used_in = pend_used_ff;
      out_v_in     = out_v_ff && !rsp_tready;
      out_cp_in    = out_cp_ff;
      out_used_in  = out_used_ff;
      out_last_in  = out_last_ff;

      if (go) begin
         case (phase_ff)
            PH_FEED: begin
               case (mode_ff)
                  MODE_UTF: begin
                     acc_in  = {acc_ff[CpW-7:0], b[5:0]};
                     cnt_in  = cnt_ff + CntW'(1);
                     cont_in = (cont_ff != 3'd0) ? cont_ff - 3'd1 : 3'd0;
                     if (cont_in == 3'd0) begin
                        emit    = 1'b1;
                        em_cp   = acc_in;
                        em_used = cnt_in;
                        mode_in = MODE_IDLE;
                        cnt_in  = '0;
                        acc_in  = '0;
                     end
                  end
                  MODE_ENTITY: begin
                     c      = cnt_ff + CntW'(1);
                     la_we  = 1'b1;
                     cnt_in = c;
                     if (c == CntW'(2) && b == CharHash) begin
                        mode_in = MODE_NUMERIC;
                        nval_in = '0;
                        nd_in   = 2'd0;
                        nrun_in = 1'b1;
                     end else begin
                        for (int e = 0; e < NumEnt; e++) begin
                           still[e] = match_ff[e] && (c <= EntLen[e]) &&
                                      (EntChar[e][c - CntW'(1)] == b);
                           if (still[e] && c == EntLen[e]) begin
                              hit     = 1'b1;
                              hit_val = EntVal[e];
                           end
                        end
                        match_in = still;
                        if (hit) begin
                           emit    = 1'b1;
                           em_cp   = CpW'(hit_val);
                           em_used = c;
                           mode_in = MODE_IDLE;
                           cnt_in  = '0;
                        end else if (still == '0) begin
                           // no entity left: send '&', replay the held letters, refeed
                           emit      = 1'b1;
                           em_cp     = CpW'(CharAmp);
                           em_used   = UsedW'(1);
                           mode_in   = MODE_IDLE;
                           cnt_in    = '0;
                           feed_done = 1'b0;
                           if (c >= CntW'(3)) begin
                              phase_in   = PH_REPLAY;
                              rp_in      = '0;
                              rp_last_in = LaIdxW'(c - CntW'(3));
                              refeed_in  = 1'b1;
                           end
                        end
                     end
                  end
                  MODE_NUMERIC: begin
                     c      = cnt_ff + CntW'(1);
                     cnt_in = c;
                     if (cnt_ff <= CntW'(4)) begin
                        if (nrun_ff && (b inside {[CharZero:CharNine]})) begin
                           nval_x10 = {1'b0, nval_ff, 3'b000} + {3'b000, nval_ff, 1'b0};
                           nval_in  = NumValW'(nval_x10 + (NumValW + 4)'(b - CharZero));
                           nd_in    = nd_ff + 2'd1;
                        end else begin
                           nrun_in = 1'b0;
                        end
                     end
                     if (c >= CntW'(6)) begin
                        emit    = 1'b1;
                        em_cp   = CpW'((nd_in != 2'd0) ? nval_in : NumValW'(CharAmp));
                        em_used = UsedW'(6);
                        mode_in = MODE_IDLE;
                        cnt_in  = '0;
                     end
                  end
                  MODE_BSLASH: begin
                     if (b == CharU) begin
                        cnt_in  = CntW'(2);
                        mode_in = MODE_BSU;
                     end else begin
                        emit      = 1'b1;
                        em_cp     = CpW'(CharBslash);
                        em_used   = UsedW'(1);
                        mode_in   = MODE_IDLE;
                        cnt_in    = '0;
                        feed_done = 1'b0;
                     end
                  end
                  MODE_BSU: begin
                     c      = cnt_ff + CntW'(1);
                     cnt_in = c;
                     if (c >= CntW'(6)) begin
                        emit    = 1'b1;
                        em_cp   = CpW'(CharSpace);
                        em_used = UsedW'(6);
                        mode_in = MODE_IDLE;
                        cnt_in  = '0;
                     end
                  end
                  default: begin
                     case (hd_item.cls)
                        CLS_LEAD: begin
                           acc_in  = CpW'(hd_item.lead_val);
                           cont_in = hd_item.extra;
                           cnt_in  = CntW'(1);
                           mode_in = MODE_UTF;
                        end
                        CLS_AMP: begin
                           cnt_in   = CntW'(1);
                           match_in = '1;
                           mode_in  = MODE_ENTITY;
                        end
                        CLS_BSLASH: begin
                           cnt_in  = CntW'(1);
                           mode_in = MODE_BSLASH;
                        end
                        default: begin
                           emit    = 1'b1;
                           em_cp   = CpW'(b);
                           em_used = UsedW'(1);
                        end
                     endcase
                  end
               endcase
               if (feed_done) begin
                  phase_in = (hd_item.end_of_text && mode_in != MODE_IDLE) ? PH_FLUSH : PH_DONE;
               end
            end
            PH_REPLAY: begin
               emit    = 1'b1;
               em_cp   = CpW'(la_ff[rp_ff]);
               em_used = UsedW'(1);
               if (rp_ff == rp_last_ff) begin
                  phase_in = refeed_ff ? PH_FEED : PH_DONE;
               end else begin
                  rp_in = rp_ff + LaIdxW'(1);
               end
            end
            PH_FLUSH: begin
               phase_in = PH_DONE;
               mode_in  = MODE_IDLE;
               cnt_in   = '0;
               cont_in  = 3'd0;
               acc_in   = '0;
               case (mode_ff)
                  MODE_UTF: begin
                     emit    = 1'b1;
                     em_used = cnt_ff;
                     case (cont_ff)
                        3'd0:    em_cp = acc_ff;
                        3'd1:    em_cp = {acc_ff[CpW-7:0], 6'b0};
                        3'd2:    em_cp = {acc_ff[CpW-13:0], 12'b0};
                        3'd3:    em_cp = {acc_ff[CpW-19:0], 18'b0};
                        default: em_cp = {acc_ff[CpW-25:0], 24'b0};
                     endcase
                  end
                  MODE_ENTITY: begin
                     emit    = 1'b1;
                     em_cp   = CpW'(CharAmp);
                     em_used = UsedW'(1);
                     if (cnt_ff >= CntW'(2)) begin
                        phase_in   = PH_REPLAY;
                        rp_in      = '0;
                        rp_last_in = LaIdxW'(cnt_ff - CntW'(2));
                        refeed_in  = 1'b0;
                     end
                  end
                  MODE_NUMERIC: begin
                     emit    = 1'b1;
                     em_cp   = CpW'(nval_res);
                     em_used = cnt_ff;
                  end
                  MODE_BSLASH: begin
                     emit    = 1'b1;
                     em_cp   = CpW'(CharBslash);
                     em_used = UsedW'(1);
                  end
                  MODE_BSU: begin
                     emit    = 1'b1;
                     em_cp   = CpW'(CharSpace);
                     em_used = cnt_ff;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
            default: begin
               // close the byte: the held result is its last one
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_cp_in   = pend_cp_ff;
                  out_used_in = pend_used_ff;
                  out_last_in = 1'b1;
                  pend_v_in   = 1'b0;
               end
               hd_pop   = 1'b1;
               phase_in = PH_FEED;
            end
         endcase

         // hold each new result until the next one shows whether it was the last
         if (emit) begin
            if (pend_v_ff) begin
               out_v_in    = 1'b1;
               out_cp_in   = pend_cp_ff;
               out_used_in = pend_used_ff;
               out_last_in = 1'b0;
            end
            pend_v_in    = 1'b1;
            pend_cp_in   = em_cp;
            pend_used_in = em_used;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FEED;
         mode_ff  <= MODE_IDLE;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         cont_ff  <= '0;
         match_ff <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         cont_ff  <= cont_in;
         match_ff <= match_in;
         pend_v_ff <= pend_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      nval_ff      <= nval_in;
      nd_ff        <= nd_in;
      nrun_ff      <= nrun_in;
      rp_ff        <= rp_in;
      rp_last_ff   <= rp_last_in;
      refeed_ff    <= refeed_in;
      pend_cp_ff   <= pend_cp_in;
      pend_used_ff <= pend_used_in;
      out_cp_ff    <= out_cp_in;
      out_used_ff  <= out_used_in;
      out_last_ff  <= out_last_in;
      if (la_we) begin
         la_ff[la_wa] <= b;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RspDataW - CpW - UsedW){1'b0}}, out_used_ff, out_cp_ff};

endmodule

/* rtl/utf8_entity_text_decoder_top.sv */
// Top level of the UTF-8 and HTML entity text decoder.
// Bytes arrive one per transfer on req_ and decode into code points on rsp_, each with the
// number of input bytes it used; rsp_tlast marks the last result caused by one input byte
// (a byte may cause none). UTF-8 lead bytes open 2 to 5 byte forms, the entities apos, amp,
// lt, gt, nbsp and quot give their ASCII characters, "&#" plus four bytes gives the value of
// up to three leading decimal digits, and backslash-u plus four bytes gives a space. A broken
// entity prefix sends '&' and replays the held bytes; req_tlast flushes pending work. The
// front end classifies bytes into a queue of QueueDepth entries, so input keeps flowing
// while the engine or the result side stalls. The engine makes one step per cycle unless
// the output stalls: a decode step and a close step per byte, plus one step for each
// replayed letter, refeed or end flush.
module utf8_entity_text_decoder_top import utf8ed_pkg::*; #(
   parameter int unsigned QueueDepth = QueueDepthDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,   // [7:0] text_byte
   input  logic                req_tlast,   // end_of_text
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [25:0] code_point, [28:26] bytes_used, rest zero
   output logic                rsp_tlast    // last_of_run
);

   logic     hd_valid;
   item_type hd_item;
   logic     hd_pop;

   // classify and queue incoming bytes
   utf8ed_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .hd_valid   (hd_valid),
      .hd_item    (hd_item),
      .hd_pop     (hd_pop)
   );

   // decode the queued byte, hold results and drive the output register
   utf8ed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .hd_valid   (hd_valid),
      .hd_item    (hd_item),
      .hd_pop     (hd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // the engine only closes a byte that is really queued
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      hd_pop |-> hd_valid)
      else $error("queue popped while empty");

   // every result used one to six bytes
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CpW+UsedW-1:CpW] != 3'd0) &&
                     (rsp_tdata[CpW+UsedW-1:CpW] != 3'd7))
      else $error("bytes_used out of range");

   // six-byte forms are numeric, named or backslash-u: all small values
   a_six_small: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[CpW+UsedW-1:CpW] == 3'd6) |-> (rsp_tdata[CpW-1:0] < 26'd1000))
      else $error("six-byte result with large code point");

   // a byte is closed only when the output register is free or being taken
   a_pop_frees_slot: assert property (@(posedge clock) disable iff (reset)
      hd_pop |-> !rsp_tvalid || rsp_tready)
      else $error("close step without output slot");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the UTF-8 and HTML entity text decoder.
module tb_top;
   import utf8ed_pkg::*;

   localparam logic [7:0] AMP    = CharAmp;
   localparam logic [7:0] BSL    = CharBslash;
   localparam logic [7:0] HASH   = CharHash;
   localparam logic [7:0] LET_U  = CharU;
   localparam logic [7:0] DIG0   = CharZero;
   localparam logic [7:0] DIG9   = CharNine;
   localparam logic [7:0] SPACE  = CharSpace;
   localparam logic [7:0] ASCII7 = AsciiTop;
   localparam int MaxPerByte     = 7;
   localparam int RandomBytes    = 150;
   localparam int StallCycles    = 300;
   localparam int StallAfter     = 80;

   // one decoded code point as it should appear on the result port
   typedef struct packed {
      logic [CpW-1:0]   cp;
      logic [UsedW-1:0] used;
      logic             last;
   } cp_result_type;

   // one text byte waiting to be sent; hold_back asks the sender to drain first
   typedef struct packed {
      logic [7:0] b;
      logic       eot;
      logic       hold_back;
   } text_item_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ByteW-1:0]    req_tdata  = '0;   // [7:0] text_byte
   logic                req_tlast  = 1'b0; // end_of_text
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;         // [25:0] code_point, [28:26] bytes_used
   logic                rsp_tlast;         // last_of_run

   // entity spellings and the characters they stand for
   string       ent_name [6] = '{"&apos;", "&amp;", "&lt;", "&gt;", "&nbsp;", "&quot;"};
   int unsigned ent_code [6] = '{39, 38, 60, 62, 32, 34};

   // decoder shadow state
   mode_type         dec_mode;
   logic [7:0]       la_buf [6];
   int               la_cnt;
   logic [CpW-1:0]   dec_acc;
   int               cont_left;

   cp_result_type cp_expected [$];
   cp_result_type step_out [$];
   logic [7:0]    refeed [$];
   text_item_type text_q [$];

   int fail_count   = 0;
   int bytes_sent   = 0;
   int results_seen = 0;
   int tx_wait      = 0;
   int rx_wait      = 0;
   int rx_hold_left = 0;
   logic hold_done  = 1'b0;
   int pause_a      = -1;
   int pause_b      = -1;

   utf8_entity_text_decoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------- predictor

   function automatic void clear_state();
      dec_mode  = MODE_IDLE;
      la_cnt    = 0;
      cont_left = 0;
      dec_acc   = '0;
   endfunction

   // queue one code point of the current byte, keeping at most seven per byte
   function automatic void put_cp(int unsigned cp, int unsigned used);
      cp_result_type r;
      if (step_out.size() >= MaxPerByte) return;
      r.cp   = cp[CpW-1:0];
      r.used = used[UsedW-1:0];
      r.last = 1'b0;
      step_out.push_back(r);
   endfunction

   // send '&' and put the other held bytes back in front of the waiting ones
   function automatic void entity_fail();
      put_cp(32'(AMP), 1);
      for (int k = la_cnt - 1; k >= 1; k--) begin
         if (k < 6) refeed.push_front(la_buf[k]);
      end
      clear_state();
   endfunction

   // value of the leading digits after "&#", '&' when there are none
   function automatic int unsigned digit_value();
      int unsigned v;
      int unsigned nd;
      logic        stop;
      v    = 0;
      nd   = 0;
      stop = 1'b0;
      for (int k = 2; k < la_cnt && k < 5; k++) begin
         if (!stop) begin
            if (la_buf[k] < DIG0 || la_buf[k] > DIG9) begin
               stop = 1'b1;
            end else begin
               v  = v * 10 + 32'(la_buf[k] - DIG0);
               nd = nd + 1;
            end
         end
      end
      return (nd != 0) ? v : 32'(AMP);
   endfunction

   function automatic void feed_one(logic [7:0] b);
      logic partial;
      logic same;
      int   hit;
      int   len;
      partial = 1'b0;
      hit     = -1;
      case (dec_mode)
         MODE_UTF: begin
            dec_acc = {dec_acc[CpW-7:0], b[5:0]};
            la_cnt++;
            if (cont_left > 0) cont_left--;
            if (cont_left == 0) begin
               put_cp(32'(dec_acc), la_cnt);
               clear_state();
            end
         end
         MODE_ENTITY: begin
            if (la_cnt < 6) begin
               la_buf[la_cnt] = b;
               la_cnt++;
            end
            if (la_cnt == 2 && b == HASH) begin
               dec_mode = MODE_NUMERIC;
            end else begin
               // first full match wins; any prefix match keeps the entity open
               for (int e = 0; e < 6; e++) begin
                  len = ent_name[e].len();
                  if (hit < 0 && la_cnt <= len) begin
                     same = 1'b1;
                     for (int k = 0; k < la_cnt; k++) begin
                        if (la_buf[k] != ent_name[e][k]) same = 1'b0;
                     end
                     if (same) begin
                        if (la_cnt == len) hit = e;
                        else partial = 1'b1;
                     end
                  end
               end
               if (hit >= 0) begin
                  put_cp(ent_code[hit], ent_name[hit].len());
                  clear_state();
               end else if (!partial) begin
                  entity_fail();
               end
            end
         end
         MODE_NUMERIC: begin
            if (la_cnt < 6) begin
               la_buf[la_cnt] = b;
               la_cnt++;
            end
            if (la_cnt >= 6) begin
               put_cp(digit_value(), 6);
               clear_state();
            end
         end
         MODE_BSLASH: begin
            if (b == LET_U) begin
               la_cnt   = 2;
               dec_mode = MODE_BSU;
            end else begin
               // lone backslash: send it and decode this byte again from idle
               put_cp(32'(BSL), 1);
               clear_state();
               refeed.push_front(b);
            end
         end
         MODE_BSU: begin
            la_cnt++;
            if (la_cnt >= 6) begin
               put_cp(32'(SPACE), 6);
               clear_state();
            end
         end
         default: begin
            clear_state();
            if (b > ASCII7) begin
               if (!b[5]) begin
                  dec_acc   = CpW'(b & 8'd31);
                  cont_left = 1;
               end else if (!b[4]) begin
                  dec_acc   = CpW'(b & 8'd15);
                  cont_left = 2;
               end else if (!b[3]) begin
                  dec_acc   = CpW'(b & 8'd7);
                  cont_left = 3;
               end else begin
                  dec_acc   = CpW'(b & 8'd3);
                  cont_left = 4;
               end
               la_cnt   = 1;
               dec_mode = MODE_UTF;
            end else if (b == AMP) begin
               la_buf[0] = b;
               la_cnt    = 1;
               dec_mode  = MODE_ENTITY;
            end else if (b == BSL) begin
               la_buf[0] = b;
               la_cnt    = 1;
               dec_mode  = MODE_BSLASH;
            end else begin
               put_cp(32'(b), 1);
            end
         end
      endcase
   endfunction

   // close whatever form is open when the end flag arrives
   function automatic void flush_pending();
      logic [63:0] wide;
      case (dec_mode)
         MODE_UTF: begin
            wide = {38'b0, dec_acc} << (6 * cont_left);
            put_cp(32'(wide[CpW-1:0]), la_cnt);
            clear_state();
         end
         MODE_ENTITY: entity_fail();
         MODE_NUMERIC: begin
            put_cp(digit_value(), la_cnt);
            clear_state();
         end
         MODE_BSLASH: begin
            put_cp(32'(BSL), 1);
            clear_state();
         end
         MODE_BSU: begin
            put_cp(32'(SPACE), la_cnt);
            clear_state();
         end
         default: clear_state();
      endcase
   endfunction

   // work out every code point one accepted byte causes and queue them
   function automatic void predict_byte(logic [7:0] b, logic eot);
      cp_result_type r;
      logic          busy;
      step_out.delete();
      refeed.delete();
      refeed.push_back(b);
      busy = 1'b1;
      while (busy) begin
         while (refeed.size() > 0) feed_one(refeed.pop_front());
         if (eot && dec_mode != MODE_IDLE) flush_pending();
         else busy = 1'b0;
      end
      if (step_out.size() > 0) begin
         r      = step_out.pop_back();
         r.last = 1'b1;
         step_out.push_back(r);
      end
      foreach (step_out[i]) cp_expected.push_back(step_out[i]);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void add_byte(logic [7:0] b, logic eot);
      text_item_type t;
      t.b         = b;
      t.eot       = eot;
      t.hold_back = (text_q.size() == pause_a) || (text_q.size() == pause_b);
      text_q.push_back(t);
   endfunction

   // random end flag, about one byte in twenty-five
   function automatic logic rnd_eot();
      return ($urandom_range(0, 24) == 0);
   endfunction

   // add a random run of text built from one decodable form or noise
   function automatic void add_random_unit();
      int       pick;
      int       e;
      int       n;
      int       extra;
      logic [7:0] lead;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         add_byte(8'($urandom_range(0, 127)), rnd_eot());
      end else if (pick < 40) begin
         lead  = 8'($urandom_range(128, 255));
         extra = !lead[5] ? 1 : !lead[4] ? 2 : !lead[3] ? 3 : 4;
         add_byte(lead, rnd_eot());
         for (int k = 0; k < extra; k++) add_byte(8'($urandom_range(0, 255)), rnd_eot());
      end else if (pick < 60) begin
         e = $urandom_range(0, 5);
         for (int k = 0; k < ent_name[e].len(); k++) add_byte(ent_name[e][k], rnd_eot());
      end else if (pick < 70) begin
         add_byte(AMP, rnd_eot());
         add_byte(HASH, rnd_eot());
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 3) != 0) add_byte(8'($urandom_range(DIG0, DIG9)), rnd_eot());
            else add_byte(8'($urandom_range(0, 255)), rnd_eot());
         end
      end else if (pick < 78) begin
         add_byte(BSL, rnd_eot());
         add_byte(LET_U, rnd_eot());
         for (int k = 0; k < 4; k++) add_byte(8'($urandom_range(0, 255)), rnd_eot());
      end else if (pick < 88) begin
         // broken entity: a true prefix followed by any byte
         e = $urandom_range(0, 5);
         n = $urandom_range(1, ent_name[e].len() - 1);
         for (int k = 0; k < n; k++) add_byte(ent_name[e][k], rnd_eot());
         add_byte(8'($urandom_range(0, 255)), rnd_eot());
      end else if (pick < 93) begin
         add_byte(BSL, rnd_eot());
         add_byte(8'($urandom_range(0, 255)), rnd_eot());
      end else begin
         add_byte(8'($urandom_range(0, 255)), rnd_eot());
      end
   endfunction

   // ---------------------------------------------------------------- clock and reset

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- sender

   // Offer the next byte whenever the channel is free; leave a random gap after each
   // transfer, except in burst phases and while the receiver is held off, so the input
   // queue of the block fills up. A hold_back byte waits until all results are in.
   always @(posedge clock) begin : byte_driver
      text_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         tx_wait = 0;
         clear_state();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_byte(req_tdata, req_tlast);
            bytes_sent <= bytes_sent + 1;
            if (((bytes_sent / 20) % 3 == 2) || rx_hold_left > 0) tx_wait = 0;
            else tx_wait = $urandom_range(0, 15);
         end
         if (!req_tvalid || req_tready) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_tvalid <= 1'b0;
            end else if (text_q.size() > 0 &&
                         !(text_q[0].hold_back && cp_expected.size() > 0)) begin
               nxt = text_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.b;
               req_tlast  <= nxt.eot;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // Hold the result side off once for a long stretch partway through the text.
   always @(posedge clock) begin : stall_timer
      if (reset) begin
         rx_hold_left <= 0;
         hold_done    <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end else if (!hold_done && bytes_sent >= StallAfter) begin
         rx_hold_left <= StallCycles;
         hold_done    <= 1'b1;
      end
   end

   // Compare each result transfer field by field with the oldest expected code point,
   // then draw the stall before taking the next one.
   always @(posedge clock) begin : result_monitor
      cp_result_type    want;
      logic [CpW-1:0]   got_cp;
      logic [UsedW-1:0] got_used;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_cp   = rsp_tdata[CpW-1:0];
            got_used = rsp_tdata[CpW+UsedW-1:CpW];
            results_seen <= results_seen + 1;
            if (cp_expected.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, got cp=%h used=%0d last=%b",
                        $time, got_cp, got_used, rsp_tlast);
            end else begin
               want = cp_expected.pop_front();
               if (got_cp !== want.cp) begin
                  fail_count++;
                  $display("%0t: code_point mismatch: expected %h, got %h",
                           $time, want.cp, got_cp);
               end
               if (got_used !== want.used) begin
                  fail_count++;
                  $display("%0t: bytes_used mismatch: expected %0d, got %0d",
                           $time, want.used, got_used);
               end
               if (rsp_tlast !== want.last) begin
                  fail_count++;
                  $display("%0t: last_of_run mismatch: expected %b, got %b",
                           $time, want.last, rsp_tlast);
               end
            end
            if ((results_seen / 30) % 3 == 1) rx_wait = 0;
            else rx_wait = $urandom_range(0, 15);
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (rx_hold_left == 0);
         end
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : text_source
      int dir_n;
      // directed text: plain, zero, short and truncated UTF-8, entities, escapes
      add_byte(8'h41, 1'b0);
      add_byte(8'h00, 1'b0);               // zero code point, decoded as plain text
      add_byte(8'hC3, 1'b0);
      add_byte(8'hA9, 1'b0);
      add_byte(8'hFF, 1'b1);               // five-byte lead cut off by the end flag
      add_byte(AMP, 1'b0);
      add_byte(8'h6C, 1'b0);
      add_byte(8'h74, 1'b0);
      add_byte(8'h3B, 1'b0);
      add_byte(AMP, 1'b0);                 // broken entity, decode the 'x' again
      add_byte(8'h78, 1'b0);
      add_byte(AMP, 1'b0);                 // numeric form flushed after one digit
      add_byte(HASH, 1'b0);
      add_byte(8'h39, 1'b1);
      add_byte(BSL, 1'b0);                 // backslash not followed by u
      add_byte(8'h71, 1'b0);
      add_byte(BSL, 1'b0);                 // backslash-u flushed early
      add_byte(LET_U, 1'b1);
      add_byte(BSL, 1'b1);                 // lone backslash at the end
      add_byte(AMP, 1'b1);                 // lone ampersand at the end
      add_byte(8'h80, 1'b0);               // continuation value used as a lead
      add_byte(8'h7F, 1'b0);
      dir_n   = text_q.size();
      pause_a = dir_n;
      pause_b = dir_n + 110;
      while (text_q.size() < dir_n + RandomBytes) add_random_unit();

      // wait for the last byte to go out, then for every result, then let it settle;
      // sample between edges so the driver's updates of this cycle are already in
      @(negedge reset);
      while (text_q.size() != 0 || req_tvalid) @(negedge clock);
      while (cp_expected.size() != 0) @(negedge clock);
      repeat (64) @(posedge clock);
      if (rsp_tvalid) begin
         fail_count++;
         $display("%0t: unexpected result left on the output: cp=%h",
                  $time, rsp_tdata[CpW-1:0]);
      end

      $display("Sent %0d text bytes (UTF-8 forms, entities, numeric and escape forms,",
               bytes_sent);
      $display("broken and truncated texts); checked %0d code points.", results_seen);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #8000000;
      $display("Verification failed");
      $finish;
   end

endmodule
